FILE: rtl/core/vbad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbad_pkg: shared types and constants of the volume block average downsampler
// Holds the size limits, the derived field widths, the register indexes and
// the structs passed between the address generator, accumulator and divider.
// ----------------------------------------------------------------------------
package vbad_pkg;

	// Size limits. MAX_CELLS must be a power of two: cube addresses wrap.
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_FACTOR = 8;
	localparam int MAX_CELLS  = 65536;
	localparam int MAX_SLICES = 65535;

	// Port widths.
	localparam int VOXW      = 8;
	localparam int MEANW     = 8;
	localparam int CFG_IDXW  = 8;
	localparam int CFG_DATAW = 16;
	localparam int WCFGW     = 11;
	localparam int HCFGW     = 11;
	localparam int NCFGW     = 16;
	localparam int FCFGW     = 4;

	// Internal widths.
	localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int ZW    = 16;
	localparam int FW    = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
	localparam int NW    = FW + 1;
	localparam int NXYW  = 2 * NW;
	localparam int CNTW  = 3 * NW;
	localparam int AW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int SUMW  = 17;
	localparam int DIVW  = CNTW + MEANW;
	localparam int NSTG  = MEANW;

	// Configuration register indexes.
	localparam logic [CFG_IDXW-1:0] REG_SLICE_WIDTH  = CFG_IDXW'(0);
	localparam logic [CFG_IDXW-1:0] REG_SLICE_HEIGHT = CFG_IDXW'(1);
	localparam logic [CFG_IDXW-1:0] REG_SLICE_COUNT  = CFG_IDXW'(2);
	localparam logic [CFG_IDXW-1:0] REG_FACTOR       = CFG_IDXW'(3);

	// One voxel on its way to the accumulator.
	typedef struct packed {
		logic [AW-1:0]   addr;
		logic [VOXW-1:0] voxel;
		logic            first;
		logic            complete;
		logic [NXYW-1:0] nxy;
		logic [NW-1:0]   nz;
		logic            last;
	} vbad_item_t;

	// A finished cube sum waiting to be divided.
	typedef struct packed {
		logic [SUMW-1:0] sum;
		logic [CNTW-1:0] cnt;
		logic            last;
	} vbad_div_req_t;

	// Payload of one divider stage.
	typedef struct packed {
		logic [SUMW-1:0]  rem;
		logic [MEANW-1:0] quo;
		logic [CNTW-1:0]  cnt;
		logic             sat;
		logic             last;
	} vbad_div_stage_t;

endpackage

FILE: rtl/core/vbad_addr_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbad_addr_gen: raster position tracking and cube addressing
// Holds the configuration and the raster counters, and tags each voxel with
// its cube address, its first/complete flags and the cube's voxel count.
// ----------------------------------------------------------------------------
module vbad_addr_gen (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr,
	input  logic [vbad_pkg::CFG_IDXW-1:0]  cfg_index,
	input  logic [vbad_pkg::CFG_DATAW-1:0] cfg_data,
	input  logic                           push,
	input  logic [vbad_pkg::VOXW-1:0]      voxel,
	output vbad_pkg::vbad_item_t           item
);
	import vbad_pkg::*;

	logic [XW-1:0] w_m1_q;
	logic [YW-1:0] h_m1_q;
	logic [ZW-1:0] n_m1_q;
	logic [FW-1:0] f_m1_q;

	logic [XW-1:0] x_q, cx_q;
	logic [FW-1:0] xm_q, ym_q, sig_q;
	logic [YW-1:0] y_q;
	logic [ZW-1:0] z_q;
	logic [AW-1:0] row_base_q;

	logic [WCFGW-1:0] wd;
	logic [HCFGW-1:0] hd;
	logic [NCFGW-1:0] nd;
	logic [FCFGW-1:0] fd;
	logic             x_end, y_end, z_end, last_slice;
	logic             at_w_end, at_h_end, at_n_end;
	logic             restart;

	assign wd = cfg_data[WCFGW-1:0];
	assign hd = cfg_data[HCFGW-1:0];
	assign nd = cfg_data[NCFGW-1:0];
	assign fd = cfg_data[FCFGW-1:0];

	assign at_w_end   = (x_q == w_m1_q);
	assign at_h_end   = (y_q == h_m1_q);
	assign at_n_end   = (z_q == n_m1_q);
	assign x_end      = (xm_q == f_m1_q) || at_w_end;
	assign y_end      = (ym_q == f_m1_q) || at_h_end;
	assign z_end      = (sig_q == f_m1_q);
	assign last_slice = z_end || at_n_end;

	assign restart = cfg_wr && ((cfg_index == REG_SLICE_WIDTH) || (cfg_index == REG_SLICE_HEIGHT)
		|| (cfg_index == REG_SLICE_COUNT) || (cfg_index == REG_FACTOR));

	always_comb begin
		item.addr     = row_base_q + AW'(cx_q);
		item.voxel    = voxel;
		item.first    = (sig_q == '0) && (xm_q == '0) && (ym_q == '0);
		item.complete = last_slice && x_end && y_end;
		item.nxy      = (NXYW'(xm_q) + NXYW'(1)) * (NXYW'(ym_q) + NXYW'(1));
		item.nz       = NW'(sig_q) + NW'(1);
		item.last     = at_w_end && at_h_end && at_n_end;
	end

	// Configuration is stored already clamped and minus one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_m1_q <= XW'(255);
			h_m1_q <= YW'(255);
			n_m1_q <= '0;
			f_m1_q <= FW'(1);
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_SLICE_WIDTH: begin
					if (wd == '0)
						w_m1_q <= '0;
					else if (wd > WCFGW'(MAX_WIDTH))
						w_m1_q <= XW'(MAX_WIDTH - 1);
					else
						w_m1_q <= XW'(wd - WCFGW'(1));
				end
				REG_SLICE_HEIGHT: begin
					if (hd == '0)
						h_m1_q <= '0;
					else if (hd > HCFGW'(MAX_HEIGHT))
						h_m1_q <= YW'(MAX_HEIGHT - 1);
					else
						h_m1_q <= YW'(hd - HCFGW'(1));
				end
				REG_SLICE_COUNT: begin
					n_m1_q <= (nd == '0) ? '0 : ZW'(nd - NCFGW'(1));
				end
				REG_FACTOR: begin
					if (fd == '0)
						f_m1_q <= '0;
					else if (fd > FCFGW'(MAX_FACTOR))
						f_m1_q <= FW'(MAX_FACTOR - 1);
					else
						f_m1_q <= FW'(fd - FCFGW'(1));
				end
				default: begin
				end
			endcase
		end
	end

	// The cube row base advances by the number of cubes in a row, which is
	// the column cube index at the row's last voxel plus one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q        <= '0;
			cx_q       <= '0;
			xm_q       <= '0;
			y_q        <= '0;
			ym_q       <= '0;
			z_q        <= '0;
			sig_q      <= '0;
			row_base_q <= '0;
		end else if (restart) begin
			x_q        <= '0;
			cx_q       <= '0;
			xm_q       <= '0;
			y_q        <= '0;
			ym_q       <= '0;
			z_q        <= '0;
			sig_q      <= '0;
			row_base_q <= '0;
		end else if (push) begin
			if (!at_w_end) begin
				x_q <= x_q + XW'(1);
				if (xm_q == f_m1_q) begin
					xm_q <= '0;
					cx_q <= cx_q + XW'(1);
				end else begin
					xm_q <= xm_q + FW'(1);
				end
			end else begin
				x_q  <= '0;
				xm_q <= '0;
				cx_q <= '0;
				if (!at_h_end) begin
					y_q <= y_q + YW'(1);
					if (ym_q == f_m1_q) begin
						ym_q       <= '0;
						row_base_q <= row_base_q + AW'(cx_q) + AW'(1);
					end else begin
						ym_q <= ym_q + FW'(1);
					end
				end else begin
					y_q        <= '0;
					ym_q       <= '0;
					row_base_q <= '0;
					if (!at_n_end) begin
						z_q   <= z_q + ZW'(1);
						sig_q <= z_end ? '0 : sig_q + FW'(1);
					end else begin
						z_q   <= '0;
						sig_q <= '0;
					end
				end
			end
		end
	end

endmodule

FILE: rtl/core/vbad_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbad_accum: cube sum memory with read-modify-write
// Reads the cube's running sum into a register when a voxel is taken, then adds
// the voxel and writes it back, forwarding the last write on an address hit.
// ----------------------------------------------------------------------------
module vbad_accum (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    push,
	input  vbad_pkg::vbad_item_t    item,
	output logic                    req_valid,
	output vbad_pkg::vbad_div_req_t req
);
	import vbad_pkg::*;

	logic [SUMW-1:0] sum_mem [MAX_CELLS];
	logic [SUMW-1:0] rd_q;

	logic            s1_valid_q;
	vbad_item_t      item_s1;
	logic            wr_valid_q;
	logic [AW-1:0]   wr_addr_q;
	logic [SUMW-1:0] wr_data_q;

	logic            fwd;
	logic [SUMW-1:0] base;
	logic [SUMW-1:0] sum;
	logic            wr_en;

	assign wr_en = adv && s1_valid_q;
	assign fwd   = wr_valid_q && (wr_addr_q == item_s1.addr);

	always_comb begin
		if (item_s1.first)
			base = '0;
		else if (fwd)
			base = wr_data_q;
		else
			base = rd_q;
		sum = base + SUMW'(item_s1.voxel);
	end

	assign req_valid = s1_valid_q && item_s1.complete;
	assign req.sum   = sum;
	assign req.cnt   = CNTW'(item_s1.nxy) * CNTW'(item_s1.nz);
	assign req.last  = item_s1.last;

	always_ff @(posedge clk) begin
		if (wr_en)
			sum_mem[item_s1.addr] <= sum;
		if (push)
			rd_q <= sum_mem[item.addr];
	end

	always_ff @(posedge clk) begin
		if (push)
			item_s1 <= item;
		if (wr_en) begin
			wr_addr_q <= item_s1.addr;
			wr_data_q <= sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			wr_valid_q <= 1'b0;
		end else begin
			if (push)
				s1_valid_q <= 1'b1;
			else if (adv)
				s1_valid_q <= 1'b0;
			if (wr_en)
				wr_valid_q <= 1'b1;
		end
	end

	a_push_only_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> adv)
		else $error("voxel taken while the pipeline is frozen");

	a_write_sets_forward: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (wr_valid_q && (wr_addr_q == $past(item_s1.addr))))
		else $error("forwarding register missed a write-back");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid |-> (req.cnt != '0))
		else $error("completed cube with zero voxel count");

endmodule

FILE: rtl/core/vbad_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbad_divider: pipelined restoring divider for the cube mean
// Produces one quotient bit per stage, most significant first, and saturates
// to the largest mean when the sum exceeds the representable quotient.
// ----------------------------------------------------------------------------
module vbad_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       req_valid,
	input  vbad_pkg::vbad_div_req_t    req,
	output logic                       res_valid,
	output logic [vbad_pkg::MEANW-1:0] res_mean,
	output logic                       res_last
);
	import vbad_pkg::*;

	logic            vld_q [NSTG];
	vbad_div_stage_t stg_q [NSTG];
	vbad_div_stage_t stg_in  [NSTG];
	vbad_div_stage_t stg_nxt [NSTG];

	always_comb begin
		stg_in[0].rem  = req.sum;
		stg_in[0].quo  = '0;
		stg_in[0].cnt  = req.cnt;
		stg_in[0].last = req.last;
		stg_in[0].sat  = (DIVW'(req.sum) >= (DIVW'(req.cnt) << MEANW));
		for (int i = 1; i < NSTG; i++)
			stg_in[i] = stg_q[i-1];
	end

	always_comb begin
		for (int i = 0; i < NSTG; i++) begin
			logic [DIVW-1:0] trial;
			trial = DIVW'(stg_in[i].cnt) << (NSTG - 1 - i);
			stg_nxt[i] = stg_in[i];
			if (DIVW'(stg_in[i].rem) >= trial) begin
				stg_nxt[i].rem = stg_in[i].rem - SUMW'(trial);
				stg_nxt[i].quo[NSTG-1-i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NSTG; i++)
				stg_q[i] <= stg_nxt[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSTG; i++)
				vld_q[i] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= req_valid;
			for (int i = 1; i < NSTG; i++)
				vld_q[i] <= vld_q[i-1];
		end
	end

	assign res_valid = vld_q[NSTG-1];
	assign res_mean  = stg_q[NSTG-1].sat ? '1 : stg_q[NSTG-1].quo;
	assign res_last  = stg_q[NSTG-1].last;

	a_frozen_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> (vld_q[NSTG-1] == $past(vld_q[NSTG-1])))
		else $error("divider output moved while frozen");

	a_valid_shifts: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && req_valid) |=> vld_q[0])
		else $error("divider dropped a request");

	a_frozen_only_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> res_valid)
		else $error("pipeline frozen with no pending result");

endmodule

FILE: rtl/core/volume_block_average_downsampler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// volume_block_average_downsampler_unit: 3D box filter average downsampler
// Averages factor-cubed voxel cubes of a raster-order volume into one mean
// each, flagging the final mean of the volume.
// ----------------------------------------------------------------------------
// The unit takes one 8-bit voxel per clock cycle while voxel_stall is low, in
// raster order (column, then row, then slice), and emits the truncated mean of
// each factor-sized cube at the voxel that completes it, in cube raster order
// within each group of slices; cubes are clipped at the volume edges. The cube
// sum memory (65536 entries of 17 bits) is read into a register when a voxel
// is taken and written back as the voxel leaves that register, with the latest
// write forwarded when consecutive voxels hit the same cube. A mean passes the
// memory read register, then an 8-stage divider that yields one quotient bit
// per stage. Holding result_stall while a mean waits on the output freezes the
// whole pipeline, and voxel_stall follows it in the same cycle. Any
// configuration write to a defined register restarts the volume at its first
// voxel; the sum memory is not cleared, since the first voxel of each cube
// overwrites its entry. If a slice has more than 65536 cubes, cube addresses
// wrap and the aliased cubes mix. Write configuration only while no voxel or
// result is in flight.
// ----------------------------------------------------------------------------
module volume_block_average_downsampler_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [vbad_pkg::CFG_IDXW-1:0]  cfg_index,
	input  logic [vbad_pkg::CFG_DATAW-1:0] cfg_data,
	input  logic                           voxel_valid,
	output logic                           voxel_stall,
	input  logic [vbad_pkg::VOXW-1:0]      voxel,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [vbad_pkg::MEANW-1:0]     mean,
	output logic                           last_of_volume
);
	import vbad_pkg::*;

	logic          adv;
	logic          push;
	vbad_item_t    item;
	logic          req_valid;
	vbad_div_req_t req;

	// Configuration writes are never held off: cfg_ready is tied high.
	assign cfg_ready = 1'b1;

	// The pipeline moves whenever the output word is absent or being taken.
	assign adv         = !(result_valid && result_stall);
	assign voxel_stall = !adv;
	assign push        = voxel_valid && adv;

	vbad_addr_gen u_addr_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.voxel     (voxel),
		.item      (item)
	);

	vbad_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.push      (push),
		.item      (item),
		.req_valid (req_valid),
		.req       (req)
	);

	vbad_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.req_valid (req_valid),
		.req       (req),
		.res_valid (result_valid),
		.res_mean  (mean),
		.res_last  (last_of_volume)
	);

endmodule

FILE: test/tb_volume_block_average_downsampler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_volume_block_average_downsampler_unit: self-checking bench of the downsampler
// Streams voxel volumes of many shapes through the unit under random idling on
// both sides and checks every cube mean and end-of-volume flag against an
// in-bench model of the cube sums, raster position and edge clipping.
// ----------------------------------------------------------------------------
module tb_volume_block_average_downsampler_unit;

	import vbad_pkg::*;

	// One result word as the unit delivers it.
	typedef struct packed {
		logic [MEANW-1:0] mean;
		logic             last;
	} mean_word_t;

	// How the voxel values of one volume are chosen.
	typedef enum int {FILL_ANY, FILL_FULL, FILL_EXTREME, FILL_DIM} fill_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDXW-1:0]  cfg_index;
	logic [CFG_DATAW-1:0] cfg_data;
	logic                 voxel_valid;
	logic                 voxel_stall;
	logic [VOXW-1:0]      voxel;
	logic                 result_valid;
	logic                 result_stall;
	logic [MEANW-1:0]     mean;
	logic                 last_of_volume;

	volume_block_average_downsampler_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.voxel_valid    (voxel_valid),
		.voxel_stall    (voxel_stall),
		.voxel          (voxel),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.mean           (mean),
		.last_of_volume (last_of_volume)
	);

	// Model state: raw register contents, raster position and one running sum
	// per cube address. Sums are only read after the cube's first voxel wrote them.
	logic [WCFGW-1:0] model_width;
	logic [HCFGW-1:0] model_height;
	logic [NCFGW-1:0] model_slices;
	logic [FCFGW-1:0] model_factor;
	int unsigned      pos_x, pos_y, pos_z, group_slice;
	logic [SUMW-1:0]  cube_sum [MAX_CELLS];

	// Means still owed by the unit, oldest first.
	mean_word_t pending_means[$];

	int  mismatch_count;
	int  means_checked;
	int  voxels_sent;
	int  settings_used;
	bit  idle_on;
	bit  drain;
	int  stall_left;

	// Clock with a 4 ns period.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Generous limit on the whole run; a correct run ends far sooner.
	initial begin
		#10_000_000;
		$display("Run timed out with %0d means outstanding.", pending_means.size());
		$display("volume_block_average_downsampler_unit: mismatch");
		$finish;
	end

	// A register value of zero acts as one, and values above the limit act as the limit.
	function automatic int unsigned effective(input int unsigned raw, input int unsigned hi);
		if (raw == 0)
			return 1;
		return (raw > hi) ? hi : raw;
	endfunction

	function automatic logic [VOXW-1:0] pick_voxel(input fill_t fill);
		case (fill)
			FILL_FULL:    return 8'hFF;
			FILL_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			FILL_DIM:     return VOXW'($urandom_range(0, 3));
			default:      return VOXW'($urandom_range(0, 255));
		endcase
	endfunction

	// Adds one accepted voxel to its cube, queues the mean when the voxel closes
	// the cube, then steps the raster position through column, row and slice.
	task automatic accumulate_voxel(input logic [VOXW-1:0] v);
		int unsigned w, h, n, f, cols, cx, cy, cube_idx, z0, nx, ny, nz, cnt, quotient;
		bit          opens_cube, last_slice, x_end, y_end;
		mean_word_t  want;
		w = effective(model_width, MAX_WIDTH);
		h = effective(model_height, MAX_HEIGHT);
		n = effective(model_slices, MAX_SLICES);
		f = effective(model_factor, MAX_FACTOR);
		cols = (w + f - 1) / f;
		cx = pos_x / f;
		cy = pos_y / f;
		// Cube addresses wrap when a slice group holds more cubes than the memory.
		cube_idx = (cy * cols + cx) % MAX_CELLS;
		opens_cube = (group_slice == 0) && (pos_x % f == 0) && (pos_y % f == 0);
		last_slice = (group_slice == f - 1) || (pos_z == n - 1);
		x_end = (pos_x % f == f - 1) || (pos_x == w - 1);
		y_end = (pos_y % f == f - 1) || (pos_y == h - 1);
		if (opens_cube)
			cube_sum[cube_idx] = SUMW'(v);
		else
			cube_sum[cube_idx] = cube_sum[cube_idx] + SUMW'(v);
		if (last_slice && x_end && y_end) begin
			z0 = pos_z - group_slice;
			nx = (f < w - cx * f) ? f : w - cx * f;
			ny = (f < h - cy * f) ? f : h - cy * f;
			nz = (f < n - z0) ? f : n - z0;
			cnt = nx * ny * nz;
			quotient = cube_sum[cube_idx] / cnt;
			want.mean = (quotient > 255) ? 8'hFF : MEANW'(quotient);
			want.last = (pos_x == w - 1) && (pos_y == h - 1) && (pos_z == n - 1);
			pending_means = {pending_means, want};
		end
		if (pos_x + 1 < w) begin
			pos_x = pos_x + 1;
		end else begin
			pos_x = 0;
			if (pos_y + 1 < h) begin
				pos_y = pos_y + 1;
			end else begin
				pos_y = 0;
				if (pos_z + 1 < n) begin
					pos_z = pos_z + 1;
					group_slice = (group_slice + 1 >= f) ? 0 : group_slice + 1;
				end else begin
					pos_z = 0;
					group_slice = 0;
				end
			end
		end
	endtask

	// Offers one voxel word, possibly after an idle burst, and returns once it
	// has been taken. Valid stays high afterwards so back-to-back words need no gap.
	task automatic send_voxel(input logic [VOXW-1:0] v);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			repeat (gap) begin
				@(negedge clk);
				voxel_valid <= 1'b0;
				voxel       <= VOXW'($urandom);
			end
		end
		@(negedge clk);
		voxel_valid <= 1'b1;
		voxel       <= v;
		@(posedge clk);
		while (voxel_stall)
			@(posedge clk);
		voxels_sent++;
		accumulate_voxel(v);
	endtask

	// Brings the unit to rest: no voxel offered, every owed mean delivered, and
	// enough stall-free cycles for voxels that close no cube to leave the pipeline.
	task automatic settle();
		@(negedge clk);
		voxel_valid <= 1'b0;
		while (pending_means.size() != 0)
			@(posedge clk);
		drain = 1'b1;
		repeat (24)
			@(posedge clk);
		drain = 1'b0;
	endtask

	// Writes one register word. A write to a defined register restarts the volume
	// in the model as in the unit; an undefined index changes nothing.
	task automatic write_register(input logic [CFG_IDXW-1:0] idx,
			input logic [CFG_DATAW-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SLICE_WIDTH:  model_width  = data[WCFGW-1:0];
			REG_SLICE_HEIGHT: model_height = data[HCFGW-1:0];
			REG_SLICE_COUNT:  model_slices = data[NCFGW-1:0];
			REG_FACTOR:       model_factor = data[FCFGW-1:0];
			default:          return;
		endcase
		pos_x = 0;
		pos_y = 0;
		pos_z = 0;
		group_slice = 0;
	endtask

	task automatic set_volume(input logic [CFG_DATAW-1:0] w, input logic [CFG_DATAW-1:0] h,
			input logic [CFG_DATAW-1:0] n, input logic [CFG_DATAW-1:0] f);
		settle();
		write_register(REG_SLICE_WIDTH, w);
		write_register(REG_SLICE_HEIGHT, h);
		write_register(REG_SLICE_COUNT, n);
		write_register(REG_FACTOR, f);
		settings_used++;
	endtask

	// Result stall comes in random bursts, and is held low while the bench drains
	// the pipeline or runs without idling.
	always @(negedge clk) begin
		if (drain || !idle_on) begin
			stall_left = 0;
			result_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			result_stall <= 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 5) - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Every accepted result word is compared with the oldest owed mean.
	always @(posedge clk) begin : check_means
		mean_word_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_means.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 40)
					$display("%0t: unexpected result word, expected none, actual mean %0d last %0d",
						$time, mean, last_of_volume);
			end else begin
				want = pending_means.pop_front();
				means_checked++;
				if (mean !== want.mean) begin
					mismatch_count++;
					if (mismatch_count <= 40)
						$display("%0t: mean expected %0d, actual %0d",
							$time, want.mean, mean);
				end
				if (last_of_volume !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= 40)
						$display("%0t: last_of_volume expected %0d, actual %0d",
							$time, want.last, last_of_volume);
				end
			end
		end
	end

	// One-voxel volumes: every voxel is its own cube and the last of its volume,
	// so the end-of-volume wrap is hit on each word. All-zero registers act as one.
	task automatic test_single_voxel_volumes();
		set_volume(16'd1, 16'd1, 16'd1, 16'd1);
		send_voxel(8'h00);
		send_voxel(8'hFF);
		send_voxel(8'hA5);
		set_volume(16'd0, 16'd0, 16'd0, 16'd0);
		send_voxel(8'h5A);
		send_voxel(8'hFF);
	endtask

	// A 3x2x3 volume with factor 2: the right column of cubes is clipped to one
	// voxel in width and the final slice group holds a single slice.
	task automatic test_clipped_cubes();
		int i;
		set_volume(16'd3, 16'd2, 16'd3, 16'd2);
		for (i = 0; i < 18; i++)
			send_voxel((i % 3 == 0) ? 8'hFF : VOXW'(i * 37 + 1));
	endtask

	// Writes to undefined indexes must leave the volume running; a write to a
	// defined register in the middle of a volume must restart it.
	task automatic test_index_and_restart();
		int i;
		set_volume(16'd2, 16'd2, 16'd2, 16'd2);
		for (i = 0; i < 4; i++)
			send_voxel(VOXW'($urandom_range(0, 255)));
		settle();
		write_register(CFG_IDXW'(4), 16'hFFFF);
		write_register(CFG_IDXW'(8'hFF), 16'h0000);
		for (i = 0; i < 4; i++)
			send_voxel(VOXW'($urandom_range(0, 255)));
		for (i = 0; i < 3; i++)
			send_voxel(8'hFF);
		settle();
		write_register(REG_FACTOR, 16'd2);
		for (i = 0; i < 8; i++)
			send_voxel(VOXW'($urandom_range(0, 255)));
	endtask

	// Registers at their widest: width and height beyond the limit, a factor
	// above the largest cube, and a slice count with every bit set. Long volumes
	// are sent only in part; the next register write restarts them.
	task automatic test_register_extremes();
		int i;
		set_volume(16'hFFFF, 16'd1, 16'd1, 16'd4);
		for (i = 0; i < 40; i++)
			send_voxel(pick_voxel(FILL_ANY));
		set_volume(16'd1, 16'hFFFF, 16'd1, 16'hFFFF);
		for (i = 0; i < 48; i++)
			send_voxel(pick_voxel(FILL_EXTREME));
		set_volume(16'd2, 16'd3, 16'd2, 16'd9);
		for (i = 0; i < 12; i++)
			send_voxel(pick_voxel(FILL_FULL));
		set_volume(16'd3, 16'd1, 16'hFFFF, 16'd2);
		for (i = 0; i < 30; i++)
			send_voxel(pick_voxel(FILL_ANY));
	endtask

	// Random small volumes. Most are sent whole, some twice in a row, and some
	// are cut off part way and abandoned by the next register write.
	task automatic test_random_volumes();
		int          i, count, sent_here;
		int unsigned total;
		logic [15:0] w, h, n, f;
		fill_t       fill;
		sent_here = 0;
		while (sent_here < 400) begin
			w = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 9));
			h = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 9));
			n = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
			f = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 15))
				: 16'($urandom_range(1, 4));
			fill = fill_t'($urandom_range(0, 3));
			idle_on = ($urandom_range(0, 3) != 0);
			set_volume(w, h, n, f);
			total = effective(w, MAX_WIDTH) * effective(h, MAX_HEIGHT) * effective(n, MAX_SLICES);
			count = ($urandom_range(0, 3) == 0) ? 2 * total : total;
			if ($urandom_range(0, 5) == 0)
				count = $urandom_range(1, total);
			for (i = 0; i < count; i++)
				send_voxel(pick_voxel(fill));
			sent_here += count;
		end
		idle_on = 1'b1;
	endtask

	// The closing part runs without idling on either side: a whole 8x4x4 volume
	// with factor 2 streams back to back, so consecutive voxels keep hitting the
	// same cube sum.
	task automatic test_back_to_back();
		int i;
		idle_on = 1'b0;
		set_volume(16'd8, 16'd4, 16'd4, 16'd2);
		for (i = 0; i < 128; i++)
			send_voxel(VOXW'($urandom_range(0, 255)));
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		voxel_valid  = 1'b0;
		voxel        = '0;
		result_stall = 1'b0;
		idle_on      = 1'b1;
		drain        = 1'b0;
		stall_left   = 0;
		mismatch_count = 0;
		means_checked  = 0;
		voxels_sent    = 0;
		settings_used  = 0;
		model_width  = WCFGW'(256);
		model_height = HCFGW'(256);
		model_slices = NCFGW'(1);
		model_factor = FCFGW'(2);
		pos_x = 0;
		pos_y = 0;
		pos_z = 0;
		group_slice = 0;
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_single_voxel_volumes();
		test_clipped_cubes();
		test_index_and_restart();
		test_register_extremes();
		test_random_volumes();
		test_back_to_back();
		settle();

		$display("Checked %0d means from %0d voxels over %0d volume shapes.",
			means_checked, voxels_sent, settings_used);
		$display("Covered clipped and short cubes, register clamping, restarts and a dense volume.");
		if (mismatch_count == 0) begin
			$display("volume_block_average_downsampler_unit: match");
		end else begin
			$display("volume_block_average_downsampler_unit: mismatch");
		end
		$finish;
	end

endmodule

FILE: volume_block_average_downsampler_unit.f
rtl/core/vbad_pkg.sv
rtl/core/vbad_addr_gen.sv
rtl/core/vbad_accum.sv
rtl/core/vbad_divider.sv
rtl/core/volume_block_average_downsampler_unit.sv
test/tb_volume_block_average_downsampler_unit.sv
